// ===== hdl/vwss_pkg.sv =====
// Shared constants, types and helpers of the stroke smoother.
`default_nettype none
package vwss_pkg;

	localparam int MAX_EVENTS_DEF = 64;

	localparam int XY_W   = 24;
	localparam int PR_W   = 16;
	localparam int TM_W   = 32;
	localparam int SPD_W  = 24;
	localparam int ZM_W   = 16;
	localparam int TSS_W  = 32;
	localparam int LIFE_W = 16;
	localparam int CFG_IW = 8;
	localparam int CFG_DW = 32;

	localparam int DIV_W  = 64;
	localparam int DIV_CW = 6;
	localparam int SQ_NW  = 64;
	localparam int SQ_RW  = 32;
	localparam int SQ_CW  = 5;
	localparam int MUL_W  = 33;

	localparam logic [CFG_IW-1:0] REG_TSS  = 8'd0;
	localparam logic [CFG_IW-1:0] REG_LIFE = 8'd1;

	localparam logic [TSS_W-1:0]  TSS_RST  = 32'd65536;
	localparam logic [LIFE_W-1:0] LIFE_RST = 16'd100;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic [PR_W-1:0]        p;
		logic [TM_W-1:0]        t;
		logic [SPD_W-1:0]       spd;
	} ev_t;

	function automatic logic [XY_W-1:0] sat_xy(input logic neg, input logic [DIV_W-1:0] mag);
		logic [DIV_W-1:0] lim;
		logic [XY_W-1:0]  r;
		lim = DIV_W'(1) << (XY_W-1);
		if (neg) begin
			if (mag > lim) r = {1'b1, {(XY_W-1){1'b0}}};
			else r = XY_W'(~mag + 1'b1);
		end else begin
			if (mag > lim - 1'b1) r = {1'b0, {(XY_W-1){1'b1}}};
			else r = mag[XY_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/velocity_weighted_stroke_smoother.sv =====
// Top level of the velocity-weighted stroke smoother.
//
//  channel  | handshake             | payload
//  input    | in_valid / in_stall   | req_type x_in y_in pressure_in time_ms zoom
//  output   | out_valid / out_stall | x_out y_out pressure_out
//  config   | cfg_wr_en             | cfg_index cfg_wr_data
//
// A start beat is stored without leaving idle. A move beat's length grows with each
// stored event, and an event whose weight is not 1 or 0 costs more, as the divider
// is run once per exponent and per Taylor term.
// Reset clears the ring pointers and sets config to its defaults; the event memory is not cleared.
// A finished result sits in the output register, so a stalled output does not
// hold up the next input beat unless that beat finishes first.
`default_nettype none
module velocity_weighted_stroke_smoother #(
	parameter int MAX_EVENTS = vwss_pkg::MAX_EVENTS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic                               req_type,
	input  wire logic signed [vwss_pkg::XY_W-1:0]   x_in,
	input  wire logic signed [vwss_pkg::XY_W-1:0]   y_in,
	input  wire logic [vwss_pkg::PR_W-1:0]          pressure_in,
	input  wire logic [vwss_pkg::TM_W-1:0]          time_ms,
	input  wire logic [vwss_pkg::ZM_W-1:0]          zoom,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic signed [vwss_pkg::XY_W-1:0]        x_out,
	output logic signed [vwss_pkg::XY_W-1:0]        y_out,
	output logic [vwss_pkg::PR_W-1:0]               pressure_out,
	input  wire logic                               cfg_wr_en,
	input  wire logic [vwss_pkg::CFG_IW-1:0]        cfg_index,
	input  wire logic [vwss_pkg::CFG_DW-1:0]        cfg_wr_data
);
	import vwss_pkg::*;

	localparam int AW     = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
	localparam int CW     = $clog2(MAX_EVENTS + 1);
	localparam int ACC_W  = 42 + AW;
	localparam int SW_W   = 18 + AW;
	localparam int WP_W   = 34 + AW;
	localparam int SUM_W  = 36;
	localparam int DIST_W = 50;

	localparam logic [5:0] ST_IDLE  = 6'd0,  ST_DX    = 6'd1,  ST_DY    = 6'd2,
	                       ST_DSUM  = 6'd3,  ST_SQ_GO = 6'd4,  ST_SQ_W  = 6'd5,
	                       ST_SP_GO = 6'd6,  ST_SP_W  = 6'd7,  ST_PUSH  = 6'd8,
	                       ST_EX_RD = 6'd9,  ST_EX_CK = 6'd10, ST_W_RD  = 6'd11,
	                       ST_W_A   = 6'd12, ST_W_AW  = 6'd13, ST_T_MUL = 6'd14,
	                       ST_T_DIV = 6'd15, ST_T_W   = 6'd16, ST_P_MUL = 6'd17,
	                       ST_P_RND = 6'd18, ST_W_FIN = 6'd19, ST_W_ACC = 6'd20,
	                       ST_W_MX  = 6'd21, ST_W_MY  = 6'd22, ST_W_MP  = 6'd23,
	                       ST_F_Z   = 6'd24, ST_F_XG  = 6'd25, ST_F_XW  = 6'd26,
	                       ST_F_YG  = 6'd27, ST_F_YW  = 6'd28, ST_F_PG  = 6'd29,
	                       ST_F_PW  = 6'd30, ST_OUT   = 6'd31;

	logic [5:0]              state_q;
	logic [TSS_W-1:0]        tss_q;
	logic [LIFE_W-1:0]       life_q;
	logic [AW-1:0]           newest_q, wslot_q, rd_addr, nxt_slot, old_slot;
	logic [CW-1:0]           count_q, widx_q;
	logic [AW:0]             old_sum;
	ev_t                     mem_q [MAX_EVENTS];
	ev_t                     rdata_q, wdata;
	logic                    mem_we;

	logic                    rtype_q;
	logic signed [XY_W-1:0]  x_q, y_q;
	logic [PR_W-1:0]         p_in_q;
	logic [TM_W-1:0]         time_q, dt_q;
	logic [ZM_W-1:0]         zoom_q;
	logic [DIST_W-1:0]       dist_q;
	logic [SQ_RW-1:0]        r_q;
	logic [SPD_W-1:0]        spd_q;
	logic [31:0]             s_q;
	logic [19:0]             a_lo;
	logic [31:0]             ty_q, pw_q;
	logic [32:0]             t_q;
	logic signed [SUM_W-1:0] tsum_q, tsum_nx;
	logic [3:0]              k_q;
	logic [1:0]              sqn_q;
	logic [16:0]             w_q;
	logic signed [ACC_W-1:0] wsx_q, wsy_q;
	logic [WP_W-1:0]         wsp_q;
	logic [SW_W-1:0]         sumw_q;
	logic [DIV_W-1:0]        den_q;
	logic [XY_W-1:0]         xres_q, yres_q;

	logic                    out_valid_q;
	logic [XY_W-1:0]         x_out_q, y_out_q;
	logic [PR_W-1:0]         p_out_q;

	logic signed [XY_W:0]    dx, dy;
	logic [XY_W:0]           adx, ady;
	logic [XY_W-1:0]         ax, ay;
	logic [MUL_W-1:0]        ma, mb;
	logic [2*MUL_W-1:0]      prod;
	logic                    div_go, div_done, sq_go, sq_done;
	logic [DIV_W-1:0]        div_num, div_den, quo;
	logic [SQ_RW-1:0]        sq_root;
	logic [DIV_W-1:0]        awsx, awsy;
	logic [32:0]             s_add;
	logic                    in_acc, out_load;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	assign nxt_slot = (newest_q == AW'(MAX_EVENTS - 1)) ? '0 : newest_q + 1'b1;
	assign old_sum  = {1'b0, newest_q} + (AW+1)'(MAX_EVENTS) - (AW+1)'(count_q) + 1'b1;
	assign old_slot = (old_sum >= (AW+1)'(MAX_EVENTS)) ?
		AW'(old_sum - (AW+1)'(MAX_EVENTS)) : old_sum[AW-1:0];

	always_comb begin
		case (state_q)
			ST_EX_RD, ST_EX_CK: rd_addr = old_slot;
			ST_IDLE, ST_DX, ST_DY, ST_DSUM, ST_SQ_GO, ST_SQ_W, ST_SP_GO, ST_SP_W,
			ST_PUSH: rd_addr = newest_q;
			default: rd_addr = wslot_q;
		endcase
	end

	assign mem_we    = (in_acc && !req_type) || (state_q == ST_PUSH);
	assign wdata.x   = in_acc ? x_in : x_q;
	assign wdata.y   = in_acc ? y_in : y_q;
	assign wdata.p   = in_acc ? pressure_in : p_in_q;
	assign wdata.t   = in_acc ? time_ms : time_q;
	assign wdata.spd = in_acc ? '0 : spd_q;

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[nxt_slot] <= wdata;
		rdata_q <= mem_q[rd_addr];
	end

	assign dx  = (XY_W+1)'(x_q) - (XY_W+1)'(rdata_q.x);
	assign dy  = (XY_W+1)'(y_q) - (XY_W+1)'(rdata_q.y);
	assign adx = dx[XY_W] ? (XY_W+1)'(-dx) : (XY_W+1)'(dx);
	assign ady = dy[XY_W] ? (XY_W+1)'(-dy) : (XY_W+1)'(dy);
	assign ax  = rdata_q.x[XY_W-1] ? XY_W'(-rdata_q.x) : XY_W'(rdata_q.x);
	assign ay  = rdata_q.y[XY_W-1] ? XY_W'(-rdata_q.y) : XY_W'(rdata_q.y);
	assign awsx = wsx_q[ACC_W-1] ? DIV_W'(-wsx_q) : DIV_W'(wsx_q);
	assign awsy = wsy_q[ACC_W-1] ? DIV_W'(-wsy_q) : DIV_W'(wsy_q);
	assign s_add = {1'b0, s_q} + 33'(rdata_q.spd);
	assign a_lo  = quo[19:0];
	assign tsum_nx = k_q[0] ? tsum_q - SUM_W'(quo[32:0]) : tsum_q + SUM_W'(quo[32:0]);

	always_comb begin
		ma = '0;
		mb = '0;
		unique case (state_q)
			ST_DX:    begin ma = MUL_W'(adx); mb = MUL_W'(adx); end
			ST_DY:    begin ma = MUL_W'(ady); mb = MUL_W'(ady); end
			ST_W_RD:  begin ma = MUL_W'(s_q); mb = MUL_W'(s_q); end
			ST_T_MUL: begin ma = t_q; mb = MUL_W'(ty_q); end
			ST_P_MUL: begin ma = MUL_W'(pw_q); mb = MUL_W'(pw_q); end
			ST_W_ACC: begin ma = MUL_W'(w_q); mb = MUL_W'(ax); end
			ST_W_MX:  begin ma = MUL_W'(w_q); mb = MUL_W'(ay); end
			ST_W_MY:  begin ma = MUL_W'(w_q); mb = MUL_W'(rdata_q.p); end
			ST_F_Z:   begin
				ma = MUL_W'(sumw_q);
				mb = (zoom_q == '0) ? MUL_W'(1) : MUL_W'(zoom_q);
			end
			default: ;
		endcase
	end

	always_comb begin
		div_go  = 1'b0;
		div_num = '0;
		div_den = '0;
		sq_go   = (state_q == ST_SQ_GO);
		unique case (state_q)
			ST_SP_GO: begin
				div_go  = 1'b1;
				div_num = DIV_W'({r_q, 1'b0});
				div_den = (dt_q == '0) ? DIV_W'(1) : DIV_W'(dt_q);
			end
			ST_W_A: begin
				div_go  = 1'b1;
				div_num = prod[DIV_W-1:0];
				div_den = (tss_q == '0) ? DIV_W'(1) : DIV_W'(tss_q);
			end
			ST_T_DIV: begin
				div_go  = 1'b1;
				div_num = DIV_W'(prod[2*MUL_W-1:32]);
				div_den = DIV_W'(k_q);
			end
			ST_F_XG: begin
				div_go  = 1'b1;
				div_num = {awsx[DIV_W-9:0], 8'd0};
				div_den = prod[DIV_W-1:0];
			end
			ST_F_YG: begin
				div_go  = 1'b1;
				div_num = {awsy[DIV_W-9:0], 8'd0};
				div_den = den_q;
			end
			ST_F_PG: begin
				div_go  = 1'b1;
				div_num = DIV_W'(wsp_q);
				div_den = DIV_W'(sumw_q);
			end
			default: ;
		endcase
	end

	vwss_mul u_mul (.clk(clk), .a(ma), .b(mb), .prod(prod));

	vwss_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go), .num(div_num), .den(div_den),
		.done(div_done), .quo(quo)
	);

	vwss_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_go), .rad({dist_q, 14'd0}),
		.done(sq_done), .root(sq_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			tss_q    <= TSS_RST;
			life_q   <= LIFE_RST;
			newest_q <= '0;
			count_q  <= '0;
		end else begin
			if (cfg_wr_en && cfg_index == REG_TSS) tss_q <= cfg_wr_data;
			if (cfg_wr_en && cfg_index == REG_LIFE) life_q <= cfg_wr_data[LIFE_W-1:0];
			unique case (state_q)
				ST_IDLE: if (in_acc) begin
					if (!req_type) begin
						newest_q <= nxt_slot;
						count_q  <= CW'(1);
					end else if (count_q == '0) begin
						state_q <= ST_PUSH;
					end else begin
						state_q <= ST_DX;
					end
				end
				ST_DX:    state_q <= ST_DY;
				ST_DY:    state_q <= ST_DSUM;
				ST_DSUM:  state_q <= ST_SQ_GO;
				ST_SQ_GO: state_q <= ST_SQ_W;
				ST_SQ_W:  if (sq_done) state_q <= ST_SP_GO;
				ST_SP_GO: state_q <= ST_SP_W;
				ST_SP_W:  if (div_done) state_q <= ST_PUSH;
				ST_PUSH: begin
					newest_q <= nxt_slot;
					if (count_q < CW'(MAX_EVENTS)) count_q <= count_q + 1'b1;
					state_q <= (time_q >= TM_W'(life_q)) ? ST_EX_RD : ST_W_RD;
				end
				ST_EX_RD: state_q <= ST_EX_CK;
				ST_EX_CK: begin
					if (count_q > CW'(1) && rdata_q.t < time_q - TM_W'(life_q)) begin
						count_q <= count_q - 1'b1;
						state_q <= ST_EX_RD;
					end else begin
						state_q <= ST_W_RD;
					end
				end
				ST_W_RD:  state_q <= ST_W_A;
				ST_W_A:   state_q <= ST_W_AW;
				ST_W_AW:  if (div_done) begin
					if (quo == '0 || quo >= DIV_W'(1 << 20)) state_q <= ST_W_ACC;
					else state_q <= ST_T_MUL;
				end
				ST_T_MUL: state_q <= ST_T_DIV;
				ST_T_DIV: state_q <= ST_T_W;
				ST_T_W:   if (div_done) state_q <= (k_q == 4'd13) ? ST_P_MUL : ST_T_MUL;
				ST_P_MUL: state_q <= ST_P_RND;
				ST_P_RND: state_q <= (sqn_q == 2'd3) ? ST_W_FIN : ST_P_MUL;
				ST_W_FIN: state_q <= ST_W_ACC;
				ST_W_ACC: state_q <= ST_W_MX;
				ST_W_MX:  state_q <= ST_W_MY;
				ST_W_MY:  state_q <= ST_W_MP;
				ST_W_MP:  state_q <= (widx_q + 1'b1 == count_q) ? ST_F_Z : ST_W_RD;
				ST_F_Z:   state_q <= ST_F_XG;
				ST_F_XG:  state_q <= ST_F_XW;
				ST_F_XW:  if (div_done) state_q <= ST_F_YG;
				ST_F_YG:  state_q <= ST_F_YW;
				ST_F_YW:  if (div_done) state_q <= ST_F_PG;
				ST_F_PG:  state_q <= ST_F_PW;
				ST_F_PW:  if (div_done) state_q <= ST_OUT;
				ST_OUT:   if (out_load) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rtype_q <= req_type;
			x_q     <= x_in;
			y_q     <= y_in;
			p_in_q  <= pressure_in;
			time_q  <= time_ms;
			zoom_q  <= zoom;
			spd_q   <= '0;
		end
		case (state_q)
			ST_DY:   begin
				dist_q <= DIST_W'(prod);
				dt_q   <= time_q - rdata_q.t;
			end
			ST_DSUM: dist_q <= dist_q + DIST_W'(prod);
			ST_SQ_W: if (sq_done) r_q <= sq_root;
			ST_SP_W: if (div_done)
				spd_q <= (quo > DIV_W'({SPD_W{1'b1}})) ? {SPD_W{1'b1}} : quo[SPD_W-1:0];
			ST_PUSH: begin
				wslot_q <= nxt_slot;
				widx_q  <= '0;
				s_q     <= '0;
				sumw_q  <= '0;
				wsx_q   <= '0;
				wsy_q   <= '0;
				wsp_q   <= '0;
			end
			ST_W_AW: if (div_done) begin
				w_q    <= (quo == '0) ? 17'd65536 : 17'd0;
				ty_q   <= {a_lo, 12'd0};
				t_q    <= 33'h1_0000_0000;
				tsum_q <= SUM_W'(33'h1_0000_0000);
				k_q    <= 4'd1;
			end
			ST_T_W: if (div_done) begin
				t_q    <= quo[32:0];
				tsum_q <= tsum_nx;
				k_q    <= k_q + 1'b1;
				sqn_q  <= '0;
				if (tsum_nx < 0) pw_q <= '0;
				else if (tsum_nx > SUM_W'(32'hFFFF_FFFF)) pw_q <= 32'hFFFF_FFFF;
				else pw_q <= tsum_nx[31:0];
			end
			ST_P_RND: begin
				pw_q  <= 32'((prod + (2*MUL_W)'(33'h0_8000_0000)) >> 32);
				sqn_q <= sqn_q + 1'b1;
			end
			ST_W_FIN: w_q <= 17'((33'(pw_q) + 33'd32768) >> 16);
			ST_W_ACC: begin
				s_q    <= s_add[32] ? 32'hFFFF_FFFF : s_add[31:0];
				sumw_q <= sumw_q + SW_W'(w_q);
			end
			ST_W_MX: wsx_q <= rdata_q.x[XY_W-1] ? wsx_q - ACC_W'(prod) : wsx_q + ACC_W'(prod);
			ST_W_MY: wsy_q <= rdata_q.y[XY_W-1] ? wsy_q - ACC_W'(prod) : wsy_q + ACC_W'(prod);
			ST_W_MP: begin
				wsp_q  <= wsp_q + WP_W'(prod);
				widx_q <= widx_q + 1'b1;
				wslot_q <= (wslot_q == '0) ? AW'(MAX_EVENTS - 1) : wslot_q - 1'b1;
			end
			ST_F_XG: den_q <= prod[DIV_W-1:0];
			ST_F_XW: if (div_done) xres_q <= sat_xy(wsx_q[ACC_W-1], quo);
			ST_F_YW: if (div_done) yres_q <= sat_xy(wsy_q[ACC_W-1], quo);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (out_load) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			x_out_q <= xres_q;
			y_out_q <= yres_q;
			p_out_q <= quo[PR_W-1:0];
		end
	end

	assign out_valid    = out_valid_q && rtype_q | out_valid_q;
	assign x_out        = x_out_q;
	assign y_out        = y_out_q;
	assign pressure_out = p_out_q;
endmodule
`default_nettype wire

// ===== hdl/vwss_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module vwss_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [vwss_pkg::DIV_W-1:0] num,
	input  wire logic [vwss_pkg::DIV_W-1:0] den,
	output logic                           done,
	output logic [vwss_pkg::DIV_W-1:0]     quo
);
	import vwss_pkg::*;

	logic [DIV_W-1:0]  rem_q, quo_q, den_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              busy_q, done_q;
	logic [DIV_W:0]    trial;

	assign trial = {rem_q, quo_q[DIV_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == DIV_CW'(DIV_W-1));
			if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CW'(DIV_W-1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= DIV_W'(trial - {1'b0, den_q});
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule
`default_nettype wire

// ===== hdl/vwss_sqrt.sv =====
// Integer square root, two radicand bits per cycle.
`default_nettype none
module vwss_sqrt (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [vwss_pkg::SQ_NW-1:0] rad,
	output logic                           done,
	output logic [vwss_pkg::SQ_RW-1:0]     root
);
	import vwss_pkg::*;

	localparam int REM_W = SQ_RW + 4;

	logic [SQ_NW-1:0] n_q;
	logic [REM_W-1:0] rem_q, rem_sh, trial;
	logic [SQ_RW-1:0] root_q;
	logic [SQ_CW-1:0] cnt_q;
	logic             busy_q, done_q;

	assign rem_sh = {rem_q[REM_W-3:0], n_q[SQ_NW-1:SQ_NW-2]};
	assign trial  = REM_W'({root_q, 2'b01});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == SQ_CW'(SQ_RW-1));
			if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == SQ_CW'(SQ_RW-1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q    <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[SQ_NW-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[SQ_RW-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[SQ_RW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule
`default_nettype wire

// ===== hdl/vwss_mul.sv =====
// Shared unsigned multiplier with registered product.
`default_nettype none
module vwss_mul (
	input  wire logic                        clk,
	input  wire logic [vwss_pkg::MUL_W-1:0]   a,
	input  wire logic [vwss_pkg::MUL_W-1:0]   b,
	output logic [2*vwss_pkg::MUL_W-1:0]     prod
);
	import vwss_pkg::*;

	logic [2*MUL_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;
endmodule
`default_nettype wire

// ===== hdl/vwss_chk.sv =====
// Port-level checks for the stroke smoother, bound to the top level.
`default_nettype none
module vwss_chk (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_stall,
	input wire logic                        req_type,
	input wire logic                        out_valid,
	input wire logic                        out_stall,
	input wire logic [vwss_pkg::XY_W-1:0]   x_out
);
	import vwss_pkg::*;

	// a move beat keeps the input stalled while it is worked on
	a_move_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && req_type |=> in_stall)
		else $error("move beat did not stall input");

	// a start beat leaves the input free
	a_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !req_type |=> !in_stall)
		else $error("start beat stalled input");

	// a result only appears at the end of a move beat's work
	a_out_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without work in progress");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(x_out))
		else $error("stalled result changed");
endmodule

bind velocity_weighted_stroke_smoother vwss_chk u_vwss_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.req_type(req_type), .out_valid(out_valid), .out_stall(out_stall), .x_out(x_out)
);
`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench of the velocity-weighted stroke smoother.
`timescale 1ns / 100ps
`default_nettype none

module tb;
	import vwss_pkg::*;

	localparam bit REQ_START = 1'b0;
	localparam bit REQ_MOVE  = 1'b1;
	localparam logic [CFG_IW-1:0] REG_NONE = 8'd7;
	localparam int RING      = 64;
	localparam int HOLD      = 3000;
	localparam int WDOG      = 400000;

	typedef struct {
		bit [XY_W-1:0] x;
		bit [XY_W-1:0] y;
		bit [PR_W-1:0] p;
	} point_t;

	class smooth_scoreboard;
		int        ex [RING];
		int        ey [RING];
		bit [31:0] ep [RING];
		bit [31:0] et [RING];
		bit [31:0] es [RING];
		int        head, cnt;
		bit [31:0] tss;
		bit [15:0] life;
		point_t    pending_points [$];
		int        errors, checked;

		function new();
			head = 0; cnt = 0; tss = TSS_RST; life = LIFE_RST;
			errors = 0; checked = 0;
		endfunction

		function void set_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] d);
			if (idx == REG_TSS) tss = d;
			else if (idx == REG_LIFE) life = d[15:0];
		endfunction

		function bit [63:0] isqrt(bit [63:0] n);
			bit [63:0] r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > n) b >>= 2;
			while (b != 0) begin
				if (n >= r + b) begin
					n -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		function bit [63:0] gauss_weight(bit [63:0] s);
			bit [63:0] d, a, yq, t, p;
			longint acc;
			int k;
			d = (tss == 0) ? 64'd1 : 64'(tss);
			a = (s * s) / d;
			if (a == 0) return 64'd65536;
			if (a >= (64'd16 << 16)) return 64'd0;
			yq = a << 12;
			t = 64'd1 << 32;
			acc = 64'sd1 << 32;
			for (k = 1; k <= 13; k++) begin
				t = ((t * yq) >> 32) / 64'(k);
				if (k & 1) acc -= longint'(t);
				else acc += longint'(t);
			end
			if (acc < 0) acc = 0;
			if (acc > 64'sh0FFFFFFFF) acc = 64'sh0FFFFFFFF;
			p = 64'(acc);
			for (k = 0; k < 4; k++) p = (p * p + (64'd1 << 31)) >> 32;
			return (p + 64'd32768) >> 16;
		endfunction

		function bit [XY_W-1:0] clip24(longint v);
			if (v > 8388607) v = 8388607;
			if (v < -8388608) v = -8388608;
			return v[XY_W-1:0];
		endfunction

		function void store(int x, int y, bit [31:0] p, bit [31:0] t, bit [31:0] spd);
			head = (head + 1) % RING;
			ex[head] = x; ey[head] = y; ep[head] = p; et[head] = t; es[head] = spd;
			if (cnt < RING) cnt++;
		endfunction

		function void note_beat(bit req, logic signed [XY_W-1:0] x, logic signed [XY_W-1:0] y,
				bit [PR_W-1:0] p, bit [TM_W-1:0] t, bit [ZM_W-1:0] z);
			int xi, yi, i, sl, old;
			bit [31:0] spd, dt, lim;
			longint dx, dy, wsx, wsy;
			bit [63:0] dsq, r, v, s, sw, w, dv, wsp, zm;
			point_t e;
			xi = x; yi = y;
			if (req == REQ_START) begin
				cnt = 0;
				store(xi, yi, p, t, 0);
				return;
			end
			spd = 0;
			if (cnt != 0) begin
				dt = t - et[head];
				dx = longint'(xi) - ex[head];
				dy = longint'(yi) - ey[head];
				dsq = 64'(dx * dx) + 64'(dy * dy);
				r = isqrt(dsq << 14);
				if (dt == 0) dt = 1;
				v = (64'd2 * r) / 64'(dt);
				spd = (v > 64'hFFFFFF) ? 32'hFFFFFF : v[31:0];
			end
			store(xi, yi, p, t, spd);
			if (t >= 32'(life)) begin
				lim = t - 32'(life);
				while (cnt > 1) begin
					old = (head + RING - (cnt - 1)) % RING;
					if (et[old] >= lim) break;
					cnt--;
				end
			end
			s = 0; sw = 0; wsx = 0; wsy = 0; wsp = 0;
			for (i = 0; i < cnt; i++) begin
				sl = (head + RING - i) % RING;
				w = gauss_weight(s);
				s += 64'(es[sl]);
				if (s > 64'hFFFFFFFF) s = 64'hFFFFFFFF;
				wsx += longint'(w) * ex[sl];
				wsy += longint'(w) * ey[sl];
				wsp += w * 64'(ep[sl]);
				sw += w;
			end
			zm = (z == 0) ? 64'd1 : 64'(z);
			dv = sw * zm;
			e.x = clip24((wsx * 256) / longint'(dv));
			e.y = clip24((wsy * 256) / longint'(dv));
			e.p = 16'(wsp / sw);
			pending_points.push_back(e);
		endfunction

		function void check_beat(logic [XY_W-1:0] x, logic [XY_W-1:0] y, logic [PR_W-1:0] p);
			point_t e;
			if (pending_points.size() == 0) begin
				$error("result with nothing expected: x %0d y %0d p %0d",
					$signed(x), $signed(y), p);
				errors++;
				return;
			end
			e = pending_points.pop_front();
			checked++;
			if (x !== e.x) begin
				$error("x_out expected %0d got %0d", $signed(e.x), $signed(x));
				errors++;
			end
			if (y !== e.y) begin
				$error("y_out expected %0d got %0d", $signed(e.y), $signed(y));
				errors++;
			end
			if (p !== e.p) begin
				$error("pressure_out expected %0d got %0d", e.p, p);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic req_type = 1'b0;
	logic signed [XY_W-1:0] x_in = '0;
	logic signed [XY_W-1:0] y_in = '0;
	logic [PR_W-1:0] pressure_in = '0;
	logic [TM_W-1:0] time_ms = '0;
	logic [ZM_W-1:0] zoom = 16'd256;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [XY_W-1:0] x_out;
	logic signed [XY_W-1:0] y_out;
	logic [PR_W-1:0] pressure_out;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IW-1:0] cfg_index = '0;
	logic [CFG_DW-1:0] cfg_wr_data = '0;

	smooth_scoreboard sb = new();
	int idle_pct = 0;
	int stall_pct = 0;
	bit hold_req = 0;
	int n_beats = 0;
	int n_settings = 0;
	int quiet = 0;

	velocity_weighted_stroke_smoother u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .x_in(x_in), .y_in(y_in), .pressure_in(pressure_in),
		.time_ms(time_ms), .zoom(zoom),
		.out_valid(out_valid), .out_stall(out_stall),
		.x_out(x_out), .y_out(y_out), .pressure_out(pressure_out),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_beat(x_out, y_out, pressure_out);
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
		else quiet++;
		if (quiet >= WDOG) begin
			$display("watchdog: no beat for %0d cycles", WDOG);
			$display("FAIL velocity_weighted_stroke_smoother");
			$finish;
		end
	end

	// long hold-off so the output register fills and the input backs up
	always begin
		@(posedge clk);
		if (hold_req) begin
			hold_req = 0;
			repeat (HOLD) begin
				out_stall <= 1'b1;
				@(posedge clk);
			end
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic send(bit req, int x, int y, bit [31:0] p, bit [31:0] t, bit [31:0] z);
		bit acc;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		x_in <= x[XY_W-1:0];
		y_in <= y[XY_W-1:0];
		pressure_in <= p[PR_W-1:0];
		time_ms <= t;
		zoom <= z[ZM_W-1:0];
		do begin
			@(negedge clk);
			acc = !in_stall;
			@(posedge clk);
		end while (!acc);
		sb.note_beat(req, x[XY_W-1:0], y[XY_W-1:0], p[PR_W-1:0], t, z[ZM_W-1:0]);
		n_beats++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_points.size() > 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] d);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wr_data <= d;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_reg(idx, d);
		@(posedge clk);
	endtask

	function automatic bit [31:0] pick_zoom();
		int c;
		c = $urandom_range(9);
		if (c == 0) return 0;
		if (c == 1) return $urandom;
		return 256;
	endfunction

	task automatic run_stroke(int moves, int mag);
		bit [31:0] tm;
		int xv, yv, i, d;
		tm = $urandom;
		xv = int'($urandom) <<< 8 >>> 8;
		yv = int'($urandom) <<< 8 >>> 8;
		send(REQ_START, xv, yv, $urandom, tm, pick_zoom());
		for (i = 0; i < moves; i++) begin
			if ($urandom_range(19) == 0) tm += $urandom;
			else if ($urandom_range(3) != 0) tm += $urandom_range(1, 60);
			case (mag)
				0: d = 0;
				1: d = 16;
				2: d = 3000;
				default: d = 0;
			endcase
			if (mag == 3) begin
				xv = int'($urandom) <<< 8 >>> 8;
				yv = int'($urandom) <<< 8 >>> 8;
			end else begin
				xv += int'($urandom_range(2 * d)) - d;
				yv += int'($urandom_range(2 * d)) - d;
			end
			send(REQ_MOVE, xv, yv, $urandom, tm, pick_zoom());
		end
	endtask

	bit [31:0] tss_set [5] = '{32'd65536, 32'd1, 32'hFFFFFFFF, 32'd0, 32'd200000};
	bit [15:0] life_set [5] = '{16'd100, 16'd0, 16'd65535, 16'd20, 16'd3000};

	initial begin
		int ph, i, target;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// move on an empty store, then extremes, repeated stamps, early stamps, expiry, wrap
		send(REQ_MOVE, 8388607, -8388608, 65535, 0, 0);
		send(REQ_START, -8388608, 8388607, 0, 5, 65535);
		send(REQ_MOVE, 8388607, -8388608, 65535, 5, 1);
		send(REQ_MOVE, 8388600, -8388600, 30000, 50, 256);
		send(REQ_MOVE, 8388600, -8388600, 100, 50, 65535);
		send(REQ_MOVE, 8388601, -8388601, 200, 60, 256);
		send(REQ_MOVE, 8388602, -8388599, 300, 400, 256);
		send(REQ_START, 0, 0, 40000, 32'hFFFFFFF0, 256);
		send(REQ_MOVE, 1, -1, 40001, 32'hFFFFFFF8, 512);
		send(REQ_MOVE, 2, -2, 40002, 32'hFFFFFFFF, 128);
		send(REQ_MOVE, 3, -3, 40003, 10, 256);
		send(REQ_MOVE, -1, 1, 65535, 10, 0);
		send(REQ_START, 1000, 1000, 1000, 1000, 256);
		send(REQ_MOVE, 1004, 997, 1200, 1001, 256);
		send(REQ_MOVE, 1008, 994, 1400, 1003, 256);
		send(REQ_MOVE, 1010, 990, 1600, 1006, 256);
		send(REQ_MOVE, -8388608, 8388607, 0, 1007, 256);
		settle();
		write_reg(REG_NONE, 32'hDEADBEEF);

		for (ph = 0; ph < 5; ph++) begin
			settle();
			write_reg(REG_TSS, tss_set[ph]);
			write_reg(REG_LIFE, 32'(life_set[ph]));
			n_settings++;
			case (ph % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 82; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 82; end
				default: begin idle_pct = 10; stall_pct = 10; end
			endcase
			if (ph == 2) run_stroke(70, 0);
			target = n_beats + 330;
			i = 0;
			while (n_beats < target) begin
				if (ph == 0 && i == 20) hold_req = 1;
				if ($urandom_range(19) == 0)
					send(REQ_MOVE, $urandom, $urandom, $urandom, $urandom, pick_zoom());
				else if ($urandom_range(14) == 0)
					run_stroke(0, 0);
				else
					run_stroke($urandom_range(1, 8), $urandom_range(3));
				i++;
			end
		end

		settle();
		idle_pct = 0;
		stall_pct = 0;
		repeat (300) @(posedge clk);
		$display("run: %0d beats sent, %0d smoothed points checked, %0d register settings",
			n_beats, sb.checked, n_settings);
		$display("idling phases: none, sender, receiver, both; one long output hold-off");
		if (sb.errors == 0 && sb.pending_points.size() == 0)
			$display("PASS velocity_weighted_stroke_smoother");
		else
			$display("FAIL velocity_weighted_stroke_smoother");
		$finish;
	end

endmodule

`default_nettype wire
